/* sv/swm_pkg.sv */
package swm_pkg;

   localparam int WINDOW_MAX_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int LEN_BITS        = 7;
   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(3);

endpackage

/* sv/sliding_window_median.sv */
// Running median filter over the last k signed samples (k = window length).
// Channels:
//   req_*  : input items (one sample each), valid/ready.
//   rsp_*  : result items (lower median of the window), valid/ready.
//   csr_*  : write of the window length k; a write empties the window.
//            Lengths of 0 act as 1, lengths above WINDOW_MAX act as WINDOW_MAX.
// No result is given until k samples have arrived after reset or after a
// length write; from then on every sample yields one result.
// Throughput: one item per cycle. The window is a row of sorted cells, each
// with an age tag; removal of the oldest cell and insertion of the new sample
// are done in one pass of parallel compares across all cells.
// The result is registered at the edge that accepts the sample; it goes
// straight to rsp_* unless the output register still holds a result.
// When the receiver stalls, a second result register holds one more result;
// req_ready drops only while both registers are full.
// Reset: window length returns to 3, the window is emptied, no result pending.
module sliding_window_median #(
   parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]     rsp_median,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [swm_pkg::LEN_BITS-1:0]      csr_window_len
);
   import swm_pkg::*;

   localparam int KW = $clog2(WINDOW_MAX + 1);
   localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   sample_type          cell_ff  [WINDOW_MAX];
   sample_type          cell_in  [WINDOW_MAX];
   logic [IW-1:0]       age_ff   [WINDOW_MAX];
   logic [IW-1:0]       age_in   [WINDOW_MAX];
   logic [KW-1:0]       fill_ff, fill_in;
   logic [LEN_BITS-1:0] len_ff;

   logic                out_valid_ff, skid_valid_ff;
   sample_type          out_data_ff, skid_data_ff;

   logic                accept;
   logic [KW-1:0]       k_len;
   logic [KW-1:0]       cnt_c;
   logic [KW:0]         half;
   logic [IW-1:0]       med_idx;
   logic [IW-1:0]       rm_idx;
   logic [IW-1:0]       age_last;
   logic                full;
   logic                res_valid;
   sample_type          res_data;
   logic                rm   [WINDOW_MAX];
   logic                le_s [WINDOW_MAX];
   logic                lec  [WINDOW_MAX];
   sample_type          cmp_c [WINDOW_MAX];
   logic [IW-1:0]       age_c [WINDOW_MAX];

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_median = out_data_ff;

   always_comb begin
      if (len_ff == '0) begin
         k_len = KW'(1);
      end else if (32'(len_ff) > WINDOW_MAX) begin
         k_len = KW'(WINDOW_MAX);
      end else begin
         k_len = KW'(len_ff);
      end
   end

   always_comb begin
      int nx;
      full     = (fill_ff >= k_len);
      age_last = IW'(k_len - KW'(1));
      cnt_c    = full ? KW'(fill_ff - KW'(1)) : fill_ff;
      rm_idx   = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         rm[i]   = full && (KW'(i) < fill_ff) && (age_ff[i] == age_last);
         le_s[i] = (cell_ff[i] <= req_sample);
         if (rm[i]) begin
            rm_idx = rm_idx | IW'(i);
         end
      end
      // compact out the oldest cell
      for (int i = 0; i < WINDOW_MAX; i++) begin
         nx = (i < WINDOW_MAX - 1) ? i + 1 : i;
         if (full && (IW'(i) >= rm_idx)) begin
            cmp_c[i] = cell_ff[nx];
            age_c[i] = age_ff[nx];
            lec[i]   = (KW'(i) < cnt_c) && le_s[nx];
         end else begin
            cmp_c[i] = cell_ff[i];
            age_c[i] = age_ff[i];
            lec[i]   = (KW'(i) < cnt_c) && le_s[i];
         end
      end
      // insert after the last cell not above the sample
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (lec[i]) begin
            cell_in[i] = cmp_c[i];
            age_in[i]  = IW'(age_c[i] + IW'(1));
         end else if (i == 0) begin
            cell_in[i] = req_sample;
            age_in[i]  = '0;
         end else if (lec[(i > 0) ? i - 1 : 0]) begin
            cell_in[i] = req_sample;
            age_in[i]  = '0;
         end else begin
            cell_in[i] = cmp_c[(i > 0) ? i - 1 : 0];
            age_in[i]  = IW'(age_c[(i > 0) ? i - 1 : 0] + IW'(1));
         end
      end
      fill_in = full ? fill_ff : KW'(fill_ff + KW'(1));
   end

   always_comb begin
      half      = (KW + 1)'(({1'b0, k_len} + (KW + 1)'(1)) >> 1);
      med_idx   = IW'(half - (KW + 1)'(1));
      res_valid = accept && (fill_in >= k_len);
      res_data  = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (IW'(i) == med_idx) begin
            res_data = res_data | cell_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_RESET;
         fill_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         len_ff  <= csr_window_len;
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < WINDOW_MAX; i++) begin
            cell_ff[i] <= cell_in[i];
            age_ff[i]  <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= res_valid;
         end
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : res_data;
      end else if (res_valid) begin
         skid_data_ff <= res_data;
      end
   end

endmodule

/* bench/tb_sliding_window_median.sv */
module tb_sliding_window_median;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW       = swm_pkg::SAMPLE_BITS_DEF;
   localparam int WMAX     = swm_pkg::WINDOW_MAX_DEF;
   localparam int LW       = swm_pkg::LEN_BITS;
   localparam int N_ITEMS  = 2000;
   localparam int LIMIT    = 1000000;
   localparam int LONG_HOLD = 150;

   localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

   typedef logic signed [SW-1:0] sample_t;
   typedef logic [LW-1:0]        len_t;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   sample_t req_sample = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   sample_t rsp_median;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   len_t    csr_window_len = swm_pkg::LEN_RESET;

   sliding_window_median u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_median     (rsp_median),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_window_len (csr_window_len)
   );

   always #4 clock = ~clock;

   // model state
   int      win_len = 3;
   sample_t arrival_q[$];
   sample_t sorted_q[$];
   sample_t median_q[$];

   sample_t sample_pending[$];
   int      offered_count = 0;
   int      taken_count = 0;
   int      req_gap = 0;
   int      rsp_hold = 0;
   int      stall_requests = 0;
   int      stall_served = 0;
   bit      burst_mode = 1'b0;
   int      mismatch_count = 0;
   int      cycle_count = 0;

   function automatic int clamp_len(len_t len);
      if (len == 0) return 1;
      if (int'(len) > WMAX) return WMAX;
      return int'(len);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sample_t draw_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return sample_t'($urandom);
         5, 6, 7:       return sample_t'($urandom_range(0, 8)) - 4;
         8: begin
            case ($urandom_range(0, 3))
               0: return S_MIN;
               1: return S_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: begin
            if ($urandom_range(0, 1) == 0) return S_MIN + sample_t'($urandom_range(0, 3));
            return S_MAX - sample_t'($urandom_range(0, 3));
         end
      endcase
   endfunction

   function automatic void apply_window_len(len_t len);
      win_len = clamp_len(len);
      arrival_q.delete();
      sorted_q.delete();
   endfunction

   // slide one sample into the window, queue the lower median once full
   function automatic void slide_in(sample_t s);
      sample_t oldest;
      int pos;
      if (arrival_q.size() >= win_len) begin
         oldest = arrival_q.pop_front();
         for (int i = 0; i < sorted_q.size(); i++) begin
            if (sorted_q[i] == oldest) begin
               sorted_q.delete(i);
               break;
            end
         end
      end
      pos = 0;
      while (pos < sorted_q.size() && sorted_q[pos] <= s) pos++;
      sorted_q.insert(pos, s);
      arrival_q.push_back(s);
      if (arrival_q.size() == win_len)
         median_q.push_back(sorted_q[(win_len + 1) / 2 - 1]);
   endfunction

   // monitor
   always @(posedge clock) begin
      sample_t want;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_window_len(csr_window_len);
         if (req_valid && req_ready) begin
            slide_in(req_sample);
            taken_count <= taken_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (median_q.size() == 0) begin
               $error("median: unexpected item, actual %0d", rsp_median);
               mismatch_count++;
            end else begin
               want = median_q.pop_front();
               if (rsp_median !== want) begin
                  $error("median: expected %0d, actual %0d", want, rsp_median);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // sender
   always @(negedge clock) begin
      if (req_valid && offered_count != taken_count) begin
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (sample_pending.size() != 0) begin
         req_sample <= sample_pending.pop_front();
         req_valid <= 1'b1;
         offered_count <= offered_count + 1;
         req_gap <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver
   always @(negedge clock) begin
      if (stall_served != stall_requests) begin
         stall_served <= stall_requests;
         rsp_hold <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic wait_idle();
      while (sample_pending.size() != 0 || offered_count != taken_count
             || median_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window_len(len_t len);
      @(negedge clock);
      csr_window_len <= len;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      len_t    first_lens[4];
      sample_t dir_k3[12];
      len_t    len;
      int      sent;
      int      phase_no;
      int      n;

      first_lens = '{len_t'(1), len_t'(64), len_t'(127), len_t'(65)};
      dir_k3 = '{S_MIN, S_MAX, sample_t'(0), sample_t'(-1), sample_t'(-1), S_MAX,
                 S_MIN, S_MIN, S_MIN, sample_t'(1), sample_t'(1), sample_t'(0)};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default length of 3, extremes and duplicates
      foreach (dir_k3[i]) sample_pending.push_back(dir_k3[i]);
      wait_idle();

      // zero length acts as one
      write_window_len('0);
      sample_pending.push_back(S_MAX);
      sample_pending.push_back(S_MIN);
      sample_pending.push_back(sample_t'(-1));
      sample_pending.push_back(sample_t'(0));
      wait_idle();

      // even length gives the lower median
      write_window_len(len_t'(2));
      sample_pending.push_back(sample_t'(5));
      sample_pending.push_back(sample_t'(-5));
      sample_pending.push_back(S_MAX);
      sample_pending.push_back(S_MIN);
      sample_pending.push_back(S_MIN);
      sample_pending.push_back(S_MAX);
      wait_idle();

      sent = 0;
      phase_no = 0;
      while (sent < N_ITEMS) begin
         if (phase_no < 4) begin
            len = first_lens[phase_no];
         end else if (phase_no == 5) begin
            len = len_t'(5);
         end else begin
            case ($urandom_range(0, 9))
               0:       len = '0;
               1:       len = len_t'($urandom_range(WMAX + 1, (1 << LW) - 1));
               2:       len = len_t'(WMAX);
               3, 4, 5: len = len_t'($urandom_range(1, 6));
               default: len = len_t'($urandom_range(1, 24));
            endcase
         end
         write_window_len(len);
         n = clamp_len(len) + $urandom_range(0, 40);
         if (phase_no == 5) begin
            // receiver holds off while the sender streams, so the block backs up
            burst_mode = 1'b1;
            stall_requests++;
            n = 60;
         end else begin
            burst_mode = ($urandom_range(0, 4) == 0);
         end
         for (int i = 0; i < n; i++) sample_pending.push_back(draw_sample());
         sent += n;
         phase_no++;
         wait_idle();
         burst_mode = 1'b0;
      end

      repeat (8) @(posedge clock);
      if (median_q.size() != 0) begin
         $error("median: %0d expected items never arrived", median_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
